@@ src/sg_segment_coalescer_core_defines.svh @@
// Assertion macros for the segment coalescer.
`ifndef SG_SEGMENT_COALESCER_CORE_DEFINES_SVH
`define SG_SEGMENT_COALESCER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SGC_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define SGC_ASSERT_ALWAYS(lbl, expr, msg)
`define SGC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/sgc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sgc_pkg;

  localparam int TABLE_ROWS = 16;
  localparam int ROW_W      = $clog2(TABLE_ROWS);

  localparam logic [31:0] WINDOW_MASK = 32'hFFF0_0000;
  localparam logic [31:0] OFFSET_MASK = 32'h000F_FFFF;
  localparam logic [31:0] WINDOW_SIZE = 32'h0010_0000;
  localparam int          WINDOW_LSB  = 20;

  localparam int Q_DEPTH = 4;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam int PADDR_W = 3;

  typedef enum logic {
    REG_ADDR64_MODE = 1'b0,
    REG_WINDOW_BASE = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [63:0] seg_addr;
    logic [31:0] seg_len;
    logic        last_seg;
  } seg_t;

  typedef struct packed {
    logic [3:0]  table_row;
    logic [31:0] table_low_word;
    logic [31:0] table_high_word;
    logic [31:0] local_addr;
    logic [31:0] run_bytes;
    logic        last_desc;
  } desc_t;

  typedef struct packed {
    logic        addr64_mode;
    logic [31:0] window_base;
  } cfg_t;

  // descriptors written into the output queue for one accepted segment
  typedef struct packed {
    logic [1:0] cnt;
    desc_t      d0;
    desc_t      d1;
  } push_t;

  typedef struct packed {
    logic             run_open;
    logic [ROW_W-1:0] row;
  } run_status_t;

  typedef struct packed {
    logic [Q_CW-1:0] count;
    logic            room;
  } q_status_t;

  function automatic desc_t desc_build(input logic [63:0]      start,
                                       input logic [31:0]      len,
                                       input logic [ROW_W-1:0] row,
                                       input cfg_t             cfg,
                                       input logic             last);
    desc_t d;
    d.table_row       = 4'(row);
    d.table_low_word  = (start[31:0] & WINDOW_MASK) | {31'b0, cfg.addr64_mode};
    d.table_high_word = cfg.addr64_mode ? start[63:32] : 32'b0;
    d.local_addr      = cfg.window_base + 32'(row) * WINDOW_SIZE
                        + (start[31:0] & OFFSET_MASK);
    d.run_bytes       = len;
    d.last_desc       = last;
    return d;
  endfunction

endpackage

`default_nettype wire

@@ src/sg_segment_coalescer_core.sv @@
// Descriptors enter the output queue as the segment transfer that closes them is accepted.
// Throughput: one segment per cycle; descriptors leave at one per cycle while desc_stall
// is low, from a four-entry queue; segments stall while fewer than two entries are free.
// Reset (rst, synchronous): clears the open run, row index, queue and both registers.
`timescale 1ns / 1ps
`default_nettype none
`include "sg_segment_coalescer_core_defines.svh"

module sg_segment_coalescer_core import sgc_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  input  wire logic               seg_valid,
  output logic                    seg_stall,
  input  wire seg_t               seg,
  output logic                    desc_valid,
  input  wire logic               desc_stall,
  output desc_t                   desc
);

  cfg_t        cfg;
  reg_idx_t    reg_sel;
  logic        wr_en;
  logic        accept;
  logic        last_accept;
  push_t       push;
  run_status_t run_status;
  q_status_t   q_status;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_t'(paddr[2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.addr64_mode <= 1'b0;
      cfg.window_base <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        REG_ADDR64_MODE: cfg.addr64_mode <= pwdata[0];
        REG_WINDOW_BASE: cfg.window_base <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_ADDR64_MODE: prdata = {31'b0, cfg.addr64_mode};
      REG_WINDOW_BASE: prdata = cfg.window_base;
      default:         prdata = '0;
    endcase
  end

  assign seg_stall   = !q_status.room;
  assign accept      = seg_valid && !seg_stall;
  assign last_accept = accept && seg.last_seg;

  sgc_run u_run (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .seg    (seg),
    .cfg    (cfg),
    .push   (push),
    .status (run_status)
  );

  sgc_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .desc       (desc),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .status     (q_status)
  );

  `SGC_ASSERT_ALWAYS(a_q_bound, q_status.count <= Q_CW'(Q_DEPTH), "output queue overflow")
  `SGC_ASSERT_NEXT(a_last_out, last_accept, desc_valid, "last transfer gave no descriptor")
  `SGC_ASSERT_NEXT(a_last_close, last_accept, run_status == '0, "run not closed after last")

endmodule

`default_nettype wire

@@ src/sgc_run.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgc_run import sgc_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        accept,
  input  wire seg_t        seg,
  input  wire cfg_t        cfg,
  output push_t            push,
  output run_status_t      status
);

  logic [63:0]      run_start, run_start_next;
  logic [31:0]      run_length, run_length_next;
  logic [ROW_W-1:0] row_index, row_index_next;
  logic             run_open, run_open_next;

  logic             same_window;
  logic             contiguous;
  logic             brk;
  logic             fresh;
  logic [63:0]      base_start;
  logic [31:0]      base_len;
  logic [ROW_W-1:0] row_new;
  logic [32:0]      sum;
  logic [31:0]      sat_len;
  desc_t            broken_desc;
  desc_t            final_desc;

  always_comb begin
    same_window = seg.seg_addr[63:WINDOW_LSB] == run_start[63:WINDOW_LSB];
    contiguous  = seg.seg_addr == run_start + {32'b0, run_length};
    brk         = run_open && !(same_window && contiguous);
    fresh       = brk || !run_open;
    base_start  = fresh ? seg.seg_addr : run_start;
    base_len    = fresh ? 32'b0 : run_length;
    if (brk) begin
      row_new = (row_index == ROW_W'(TABLE_ROWS - 1)) ? '0 : row_index + 1'b1;
    end else begin
      row_new = row_index;
    end
    sum     = {1'b0, base_len} + {1'b0, seg.seg_len};
    sat_len = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    broken_desc = desc_build(run_start, run_length, row_index, cfg, 1'b0);
    final_desc  = desc_build(base_start, sat_len, row_new, cfg, 1'b1);
  end

  always_comb begin
    push.cnt = '0;
    push.d0  = broken_desc;
    push.d1  = final_desc;
    if (accept) begin
      push.cnt = {1'b0, brk} + {1'b0, seg.last_seg};
      if (!brk) begin
        push.d0 = final_desc;
      end
    end
  end

  always_comb begin
    run_start_next  = run_start;
    run_length_next = run_length;
    row_index_next  = row_index;
    run_open_next   = run_open;
    if (accept) begin
      if (seg.last_seg) begin
        run_start_next  = '0;
        run_length_next = '0;
        row_index_next  = '0;
        run_open_next   = 1'b0;
      end else begin
        run_start_next  = base_start;
        run_length_next = sat_len;
        row_index_next  = row_new;
        run_open_next   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_start  <= '0;
      run_length <= '0;
      row_index  <= '0;
      run_open   <= 1'b0;
    end else begin
      run_start  <= run_start_next;
      run_length <= run_length_next;
      row_index  <= row_index_next;
      run_open   <= run_open_next;
    end
  end

  assign status.run_open = run_open;
  assign status.row      = row_index;

endmodule

`default_nettype wire

@@ src/sgc_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sgc_outq import sgc_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire push_t push,
  output desc_t      desc,
  output logic       desc_valid,
  input  wire logic  desc_stall,
  output q_status_t  status
);

  desc_t           mem [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr, wr_ptr_next;
  logic [Q_AW-1:0] rd_ptr, rd_ptr_next;
  logic [Q_CW-1:0] count, count_next;
  logic            pop;

  assign desc_valid = count != '0;
  assign desc       = mem[rd_ptr];
  assign pop        = desc_valid && !desc_stall;

  always_comb begin
    wr_ptr_next = wr_ptr + Q_AW'(push.cnt);
    rd_ptr_next = rd_ptr + Q_AW'(pop);
    count_next  = count + Q_CW'(push.cnt) - Q_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem[wr_ptr] <= push.d0;
    end
    if (push.cnt == 2'd2) begin
      mem[wr_ptr + 1'b1] <= push.d1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  // a segment may yield two descriptors
  assign status.count = count;
  assign status.room  = count <= Q_CW'(Q_DEPTH - 2);

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import sgc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 325;

  typedef struct {
    seg_t  s;
    bit    typed;
    desc_t want;
  } plan_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  wire logic [31:0]   prdata;
  wire logic          pready;
  logic               seg_valid = 1'b0;
  wire logic          seg_stall;
  seg_t               seg_in = '0;
  wire logic          desc_valid;
  logic               desc_stall = 1'b0;
  desc_t              desc_out;

  sg_segment_coalescer_core dut (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg        (seg_in),
    .desc_valid (desc_valid),
    .desc_stall (desc_stall),
    .desc       (desc_out)
  );

  // predictor state
  logic             mode64 = 1'b0;
  logic [31:0]      win_base = '0;
  logic [63:0]      cur_start = '0;
  logic [31:0]      cur_len = '0;
  logic [ROW_W-1:0] cur_row = '0;
  logic             run_active = 1'b0;

  desc_t     pending_descs[$];
  plan_row_t plan[$];
  int        mismatches = 0;
  int        cycle_count = 0;
  bit        in_calm = 1'b0;
  int        rx_hold = 0;
  int        rx_wait;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  function automatic int idle_cycles();
    return in_calm ? 0 : $urandom_range(6);
  endfunction

  function automatic desc_t build_descriptor(input logic is_last);
    desc_t d;
    d.table_row       = 4'(cur_row);
    d.table_low_word  = (cur_start[31:0] & WINDOW_MASK) | {31'b0, mode64};
    d.table_high_word = mode64 ? cur_start[63:32] : 32'b0;
    d.local_addr      = win_base + 32'(cur_row) * WINDOW_SIZE + (cur_start[31:0] & OFFSET_MASK);
    d.run_bytes       = cur_len;
    d.last_desc       = is_last;
    return d;
  endfunction

  function automatic void coalesce_segment(input seg_t s);
    logic [32:0] sum;
    if (!run_active) begin
      cur_start  = s.seg_addr;
      cur_len    = '0;
      run_active = 1'b1;
    end else if (s.seg_addr[63:WINDOW_LSB] != cur_start[63:WINDOW_LSB] ||
                 s.seg_addr != cur_start + 64'(cur_len)) begin
      pending_descs.push_back(build_descriptor(1'b0));
      cur_row   = ROW_W'((int'(cur_row) + 1) % TABLE_ROWS);
      cur_start = s.seg_addr;
      cur_len   = '0;
    end
    sum     = {1'b0, cur_len} + {1'b0, s.seg_len};
    cur_len = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    if (s.last_seg) begin
      pending_descs.push_back(build_descriptor(1'b1));
      run_active = 1'b0;
      cur_start  = '0;
      cur_len    = '0;
      cur_row    = '0;
    end
  endfunction

  function automatic desc_t mk_desc(input logic [3:0] r, input logic [31:0] lo,
                                    input logic [31:0] hi, input logic [31:0] la,
                                    input logic [31:0] nb, input logic l);
    return desc_t'{r, lo, hi, la, nb, l};
  endfunction

  function automatic void add_row(input logic [63:0] a, input logic [31:0] n, input logic l,
                                  input bit typed = 1'b0, input desc_t want = '0);
    plan_row_t p;
    p.s     = seg_t'{a, n, l};
    p.typed = typed;
    p.want  = want;
    plan.push_back(p);
  endfunction

  task automatic reg_write(input reg_idx_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ADDR64_MODE: mode64 = val[0];
      REG_WINDOW_BASE: win_base = val;
      default: ;
    endcase
  endtask

  // one segment transfer; the typed expectation replaces the newest predicted descriptor
  task automatic push_seg(input seg_t s, input bit typed = 1'b0, input desc_t want = '0);
    int gap;
    gap = idle_cycles();
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_valid <= 1'b1;
    seg_in    <= s;
    do @(posedge clk); while (seg_stall);
    coalesce_segment(s);
    if (typed && pending_descs.size() != 0)
      pending_descs[pending_descs.size() - 1] = want;
    if ($urandom_range(39) == 0)
      in_calm = !in_calm;
  endtask

  task automatic drain(input int settle);
    while (pending_descs.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  function automatic logic [63:0] pick_addr();
    case ($urandom_range(3))
      0: return {$urandom, $urandom};
      1: return {32'h0, $urandom};
      2: return {32'hFFFF_FFFF, $urandom};
      default: return {$urandom, 12'($urandom), 20'hFFFC0 | 20'($urandom_range(63))};
    endcase
  endfunction

  function automatic logic [31:0] pick_len();
    case ($urandom_range(7))
      0: return 32'h0;
      1: return $urandom;
      2: return 32'hFFFF_FF00 | 32'($urandom_range(255));
      default: return 32'($urandom_range(1, 4096));
    endcase
  endfunction

  task automatic random_phase(input int count);
    int          sent;
    int          n;
    int          k;
    logic [63:0] a;
    logic [31:0] len;
    seg_t        s;
    sent = 0;
    while (sent < count) begin
      n   = ($urandom_range(9) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 6);
      a   = pick_addr();
      len = pick_len();
      for (k = 0; k < n && sent < count; k++) begin
        if ($urandom_range(11) == 0) begin
          s = seg_t'{{$urandom, $urandom}, $urandom, 1'($urandom)};
        end else begin
          if (k != 0) begin
            case ($urandom_range(9))
              0, 1:    a = pick_addr();
              2:       a = a + 64'(len) + 64'($urandom_range(1, 64));
              default: a = a + 64'(len);
            endcase
            len = pick_len();
          end
          s = seg_t'{a, len, (k == n - 1) || (sent == count - 1)};
        end
        if (sent == count - 1)
          s.last_seg = 1'b1;
        push_seg(s);
        sent++;
      end
    end
    seg_valid <= 1'b0;
  endtask

  // descriptor side: check each transfer, then draw the next stall
  always @(posedge clk) begin
    if (rst) begin
      desc_stall <= 1'b0;
      rx_hold    <= 0;
    end else if (desc_valid && !desc_stall) begin
      if (pending_descs.size() == 0) begin
        flag_mismatch($sformatf("unexpected descriptor %p", desc_out));
      end else begin
        if (desc_out.table_row !== pending_descs[0].table_row)
          flag_mismatch($sformatf("table_row %0h, want %0h",
                                  desc_out.table_row, pending_descs[0].table_row));
        if (desc_out.table_low_word !== pending_descs[0].table_low_word)
          flag_mismatch($sformatf("table_low_word %08h, want %08h",
                                  desc_out.table_low_word, pending_descs[0].table_low_word));
        if (desc_out.table_high_word !== pending_descs[0].table_high_word)
          flag_mismatch($sformatf("table_high_word %08h, want %08h",
                                  desc_out.table_high_word, pending_descs[0].table_high_word));
        if (desc_out.local_addr !== pending_descs[0].local_addr)
          flag_mismatch($sformatf("local_addr %08h, want %08h",
                                  desc_out.local_addr, pending_descs[0].local_addr));
        if (desc_out.run_bytes !== pending_descs[0].run_bytes)
          flag_mismatch($sformatf("run_bytes %08h, want %08h",
                                  desc_out.run_bytes, pending_descs[0].run_bytes));
        if (desc_out.last_desc !== pending_descs[0].last_desc)
          flag_mismatch($sformatf("last_desc %0b, want %0b",
                                  desc_out.last_desc, pending_descs[0].last_desc));
        void'(pending_descs.pop_front());
      end
      rx_wait = idle_cycles();
      rx_hold    <= rx_wait;
      desc_stall <= (rx_wait != 0);
    end else if (rx_hold > 1) begin
      rx_hold <= rx_hold - 1;
    end else begin
      rx_hold    <= 0;
      desc_stall <= 1'b0;
    end
  end

  initial begin
    // single segments at the field extremes
    add_row(64'h0, 32'h0, 1'b1, 1'b1,
            mk_desc(4'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1));
    add_row(64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1,
            mk_desc(4'h0, 32'hFFF0_0000, 32'h0, 32'h000F_FFFF, 32'hFFFF_FFFF, 1'b1));
    // contiguous merge with a zero-length segment
    add_row(64'h1000, 32'h100, 1'b0);
    add_row(64'h1100, 32'h200, 1'b0);
    add_row(64'h1300, 32'h0, 1'b0);
    add_row(64'h1300, 32'h10, 1'b1, 1'b1,
            mk_desc(4'h0, 32'h0, 32'h0, 32'h1000, 32'h310, 1'b1));
    // break, then merge into the second row
    add_row(64'h2000, 32'h10, 1'b0);
    add_row(64'h5000, 32'h20, 1'b0, 1'b1,
            mk_desc(4'h0, 32'h0, 32'h0, 32'h2000, 32'h10, 1'b0));
    add_row(64'h5020, 32'h1, 1'b1, 1'b1,
            mk_desc(4'h1, 32'h0, 32'h0, 32'h0010_5000, 32'h21, 1'b1));
    // contiguous across a window edge, then break with last
    add_row(64'hF_FF00, 32'h100, 1'b0);
    add_row(64'h10_0000, 32'h4, 1'b0);
    add_row(64'h30_0000, 32'h8, 1'b1);
    // length saturation
    add_row(64'h40_0000, 32'h10, 1'b0);
    add_row(64'h40_0010, 32'hFFFF_FFFF, 1'b0);
    add_row(64'h40_0010, 32'h0, 1'b1);
    // address wrap at the top of the bus space
    add_row(64'hFFFF_FFFF_FFFF_FFF0, 32'h10, 1'b0);
    add_row(64'h0, 32'h5, 1'b1);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    foreach (plan[i])
      push_seg(plan[i].s, plan[i].typed, plan[i].want);
    seg_valid <= 1'b0;

    drain(5);
    reg_write(REG_ADDR64_MODE, 32'h1);
    reg_write(REG_WINDOW_BASE, 32'hFFFF_FFFF);
    random_phase(PHASE_ITEMS);

    drain(5);
    reg_write(REG_ADDR64_MODE, 32'hFFFF_FFFE);
    reg_write(REG_WINDOW_BASE, 32'h8000_0000);
    random_phase(PHASE_ITEMS);

    drain(5);
    reg_write(REG_ADDR64_MODE, 32'h1);
    reg_write(REG_WINDOW_BASE, $urandom);
    random_phase(PHASE_ITEMS);

    drain(5);
    reg_write(REG_WINDOW_BASE, 32'h0);
    random_phase(PHASE_ITEMS);

    drain(5);
    reg_write(REG_ADDR64_MODE, 32'h0);
    reg_write(REG_WINDOW_BASE, $urandom);
    random_phase(PHASE_ITEMS);

    drain(10);
    if (pending_descs.size() != 0)
      flag_mismatch($sformatf("%0d descriptors never arrived", pending_descs.size()));
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
